### rtl/core/touch_frame_parser_macros.svh
// Assertion macros used by the checker file of the touch frame parser.
`ifndef TOUCH_FRAME_PARSER_MACROS_SVH
`define TOUCH_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define TFP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch frame parser check failed");

// Next-cycle implication, ignored while reset is high.
`define TFP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch frame parser check failed");

// Next-cycle implication that is also checked across reset.
`define TFP_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("touch frame parser reset check failed");

`endif

### rtl/core/tfp_pkg.sv
package tfp_pkg;

  localparam int MAX_PAYLOAD = 15;
  localparam int FIELD_CHARS = 5;

  // Hunt states.
  localparam logic [3:0] HS_S    = 4'd0;
  localparam logic [3:0] HS_E    = 4'd1;
  localparam logic [3:0] HS_G    = 4'd2;
  localparam logic [3:0] HS_3    = 4'd3;
  localparam logic [3:0] HS_6    = 4'd4;
  localparam logic [3:0] HS_0    = 4'd5;
  localparam logic [3:0] HS_ID   = 4'd6;
  localparam logic [3:0] HS_LEN  = 4'd7;
  localparam logic [3:0] HS_DATA = 4'd8;

  // Number parse phases.
  localparam logic [1:0] PH_SPACES = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] FRAME_ID = 8'h01;

  // floor(n / 5) = (n * Y_RECIP) >> Y_SHIFT for every n below 2**22.
  localparam logic [19:0] Y_RECIP = 20'd838861;
  localparam int          Y_SHIFT = 22;

  localparam int COORD_W = 17;

  typedef struct packed {
    logic [1:0]         phase;
    logic [COORD_W-1:0] acc;
  } parse_t;

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h73;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h67;
      3'd3: ch = 8'h33;
      3'd4: ch = 8'h36;
      3'd5: ch = 8'h30;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/tfp_digit.sv
module tfp_digit
  import tfp_pkg::*;
(
  input  parse_t     cur,
  input  logic [7:0] ch,
  output parse_t     nxt
);

  logic        is_digit;
  logic [20:0] times_ten;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  // acc * 10 + digit, kept to the coordinate width.
  assign times_ten = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                   + {17'd0, ch[3:0]};

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_SPACES: begin
        if (ch == CH_SPACE) begin
          nxt = cur;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
          nxt.phase = PH_DIGITS;
        end else if (is_digit) begin
          nxt.acc   = {13'd0, ch[3:0]};
          nxt.phase = PH_DIGITS;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          nxt.acc = times_ten[COORD_W-1:0];
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

### rtl/core/touch_frame_parser.sv
// Touch frame parser.
// The input channel (s_*) carries one received serial byte per item. The
// parser hunts for the header "seg360", then an ID byte of 0x01 and a length
// byte of 1 to 15, and then collects that many payload bytes of the form
// "x,y,p". Any header, ID or length mismatch drops the byte and restarts
// the hunt.
// The output channel (m_*) carries one item per completed frame: scaled x
// and y, the pressure code and a touching flag in tuser. When the pen code
// is not '1' or '3' the item is all zeros.
// Throughput is one byte per cycle until a stalled receiver has filled the
// stages. The result of a frame passes these registers in order on its way
// to the output channel: the input register holds the byte, the parse logic
// loads the frame stage, a scaling stage follows, and the divide-by-five
// multiply feeds the output register.
// Each stage holds its item while the next one is full, so a stalled
// receiver fills the stages one by one before s_tready drops; bubbles are
// squeezed out. Reset empties every stage, returns the hunt to waiting for
// 's' and sets the pen code to '0'.
module touch_frame_parser
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [16:0] x_pos, [33:17] y_pos, [35:34] pressure, zeros above
  output logic        m_tuser    // [0] touching
);

  // Stage 1: input register.
  logic       v1;
  logic [7:0] b1;

  // Stage 2: captured frame result.
  logic               v2;
  logic [COORD_W-1:0] xa2;
  logic [COORD_W-1:0] ya2;
  logic [1:0]         pr2;
  logic               t2;

  // Stage 3: x scaled, y times six.
  logic               v3;
  logic [COORD_W-1:0] x3;
  logic [19:0]        y3;
  logic [1:0]         pr3;
  logic               t3;

  // Stage 4: output register.
  logic [COORD_W-1:0] x_pos;
  logic [COORD_W-1:0] y_pos;
  logic [1:0]         pressure;
  logic               touching;

  logic ready2;
  logic ready3;
  logic ready4;
  logic take1;

  // Parser state.
  logic [3:0] hunt;
  logic [3:0] hunt_next;
  logic [3:0] left;
  logic [3:0] left_next;
  logic [3:0] left_dec;
  logic [1:0] fnum;
  logic [1:0] fnum_next;
  logic [2:0] fcc;
  logic [2:0] fcc_next;
  parse_t     xs;
  parse_t     xs_next;
  parse_t     ys;
  parse_t     ys_next;
  parse_t     x_fed;
  parse_t     y_fed;
  logic [7:0] pen;
  logic [7:0] pen_next;
  logic       frame_done;
  logic       touch_next;

  logic [19:0] x_times5;
  logic [19:0] y_times6;
  logic [39:0] y_prod;

  assign ready4   = !m_tvalid || m_tready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign s_tready = !v1 || ready2;
  assign take1    = v1 && ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
    if (s_tready) begin
      b1 <= s_tdata;
    end
  end

  tfp_digit u_x_digit (.cur(xs), .ch(b1), .nxt(x_fed));
  tfp_digit u_y_digit (.cur(ys), .ch(b1), .nxt(y_fed));

  assign left_dec = (left != 4'd0) ? left - 4'd1 : left;

  always_comb begin
    hunt_next  = hunt;
    left_next  = left;
    fnum_next  = fnum;
    fcc_next   = fcc;
    xs_next    = xs;
    ys_next    = ys;
    pen_next   = pen;
    frame_done = 1'b0;
    case (hunt)
      HS_S, HS_E, HS_G, HS_3, HS_6, HS_0: begin
        if (b1 == header_char(hunt[2:0])) begin
          hunt_next = hunt + 4'd1;
        end else begin
          hunt_next = HS_S;
        end
      end
      HS_ID: begin
        hunt_next = (b1 == FRAME_ID) ? HS_LEN : HS_S;
      end
      HS_LEN: begin
        if (b1 >= 8'd1 && b1 <= 8'(MAX_PAYLOAD)) begin
          left_next = b1[3:0];
          fnum_next = 2'd0;
          fcc_next  = 3'd0;
          xs_next   = '{phase: PH_SPACES, acc: '0};
          ys_next   = '{phase: PH_SPACES, acc: '0};
          hunt_next = HS_DATA;
        end else begin
          hunt_next = HS_S;
        end
      end
      HS_DATA: begin
        if (b1 == CH_COMMA) begin
          if (fnum != 2'd3) begin
            fnum_next = fnum + 2'd1;
          end
          fcc_next = 3'd0;
        end else if (fnum == 2'd2) begin
          pen_next = b1;
        end else if (fnum < 2'd2 && fcc < 3'(FIELD_CHARS)) begin
          if (fnum == 2'd0) begin
            xs_next = x_fed;
          end else begin
            ys_next = y_fed;
          end
          fcc_next = fcc + 3'd1;
        end
        left_next = left_dec;
        if (left_dec == 4'd0) begin
          hunt_next  = HS_S;
          frame_done = 1'b1;
        end
      end
      default: hunt_next = HS_S;
    endcase
  end

  assign touch_next = (pen_next == CH_ONE) || (pen_next == CH_THREE);

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt <= HS_S;
      left <= 4'd0;
      fnum <= 2'd0;
      fcc  <= 3'd0;
      xs   <= '{phase: PH_SPACES, acc: '0};
      ys   <= '{phase: PH_SPACES, acc: '0};
      pen  <= CH_ZERO;
    end else if (take1) begin
      hunt <= hunt_next;
      left <= left_next;
      fnum <= fnum_next;
      fcc  <= fcc_next;
      xs   <= xs_next;
      ys   <= ys_next;
      pen  <= pen_next;
    end
  end

  // Stage 2 captures the accumulators of a finished frame, zeroed when the
  // pen is up so that the scaled values come out as zero too.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= take1 && frame_done;
    end
    if (ready2) begin
      xa2 <= touch_next ? xs_next.acc : '0;
      ya2 <= touch_next ? ys_next.acc : '0;
      pr2 <= touch_next ? pen_next[1:0] : 2'd0;
      t2  <= touch_next;
    end
  end

  // x * 1280 / 1024 is x * 5 / 4; y * 720 / 600 is y * 6 / 5.
  assign x_times5 = {1'b0, xa2, 2'b00} + {3'b000, xa2};
  assign y_times6 = {1'b0, ya2, 2'b00} + {2'b00, ya2, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3) begin
      x3  <= x_times5[18:2];
      y3  <= y_times6;
      pr3 <= pr2;
      t3  <= t2;
    end
  end

  assign y_prod = y3 * Y_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready4) begin
      m_tvalid <= v3;
    end
    if (ready4) begin
      x_pos    <= x3;
      y_pos    <= y_prod[Y_SHIFT+COORD_W-1:Y_SHIFT];
      pressure <= pr3;
      touching <= t3;
    end
  end

  assign m_tdata = {4'd0, pressure, y_pos, x_pos};
  assign m_tuser = touching;

endmodule

### rtl/core/tfp_checker.sv
`include "touch_frame_parser_macros.svh"

module tfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  logic pen_up_item;
  logic pen_down_item;
  logic stalled;

  assign pen_up_item   = m_tvalid && !m_tuser;
  assign pen_down_item = m_tvalid && m_tuser;
  assign stalled       = m_tvalid && !m_tready;

  // An item reported with the pen up carries no position or pressure.
  `TFP_ASSERT_NOW(a_pen_up_zero, pen_up_item, m_tdata == 40'd0)
  // A touching item reports pressure 1 or 3 and zero padding.
  `TFP_ASSERT_NOW(a_pen_down_code, pen_down_item,
    (m_tdata[39:34] == 6'b000001) || (m_tdata[39:34] == 6'b000011))
  // A stalled result stays put until it is taken.
  `TFP_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // Reset leaves no result pending.
  `TFP_ASSERT_RST(a_reset_empty, rst, !m_tvalid)

endmodule

bind touch_frame_parser tfp_checker u_tfp_checker (.*);

### tb/touch_frame_parser_tb.sv
`timescale 1ns / 1ps

module touch_frame_parser_tb;
  import tfp_pkg::*;

  // Receiver hold-off used to fill the pipeline and stall the input side.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Cycles run on after the last pending result has been taken.
  localparam int DRAIN_CYCLES = 20;

  // Frame header as it arrives on the wire, first character in the top byte.
  localparam logic [47:0] SYNC_WORD = "seg360";

  typedef struct packed {
    logic               touching;
    logic [1:0]         pressure;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] x_pos;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;    // [16:0] x_pos, [33:17] y_pos, [35:34] pressure, zeros above
  logic        m_tuser;    // [0] touching

  touch_frame_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the parser state, advanced once per accepted byte.
  logic [3:0]  hunt_st;
  logic [3:0]  bytes_left;
  logic [1:0]  field_no;
  logic [2:0]  char_cnt;
  parse_t      x_parse;
  parse_t      y_parse;
  logic [7:0]  pen;

  frame_result_t pending_frames[$];
  logic [7:0]    burst[$];
  logic [7:0]    payload[$];

  int sender_idle_pct;
  int recv_stall_pct;
  int sent_bytes;
  int mismatches;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  function automatic logic [7:0] sync_char(input int idx);
    return SYNC_WORD[8*(5-idx) +: 8];
  endfunction

  function automatic logic [7:0] rand_non_comma();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_COMMA);
    return b;
  endfunction

  // One character of an atoi-style read: spaces, an optional sign, digits.
  function automatic parse_t parse_char(input parse_t p, input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (p.phase == PH_SPACES) begin
      if (c != CH_SPACE) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          p.phase = PH_DIGITS;
        end else if (is_digit) begin
          p.acc = COORD_W'(c - CH_ZERO);
          p.phase = PH_DIGITS;
        end else begin
          p.phase = PH_DONE;
        end
      end
    end else if (p.phase == PH_DIGITS) begin
      if (is_digit) begin
        p.acc = COORD_W'(p.acc * 10 + (c - CH_ZERO));
      end else begin
        p.phase = PH_DONE;
      end
    end
    return p;
  endfunction

  task automatic start_frame_state(input logic [3:0] len);
    bytes_left = len;
    field_no = '0;
    char_cnt = '0;
    x_parse = '{phase: PH_SPACES, acc: '0};
    y_parse = '{phase: PH_SPACES, acc: '0};
  endtask

  // Advances the shadow state by one byte and queues the frame result that
  // the byte completes, if any.
  task automatic predict_byte(input logic [7:0] c);
    frame_result_t res;
    if (hunt_st <= HS_0) begin
      hunt_st = (c == sync_char(hunt_st)) ? hunt_st + 4'd1 : HS_S;
    end else if (hunt_st == HS_ID) begin
      hunt_st = (c == FRAME_ID) ? HS_LEN : HS_S;
    end else if (hunt_st == HS_LEN) begin
      if (c >= 1 && c <= MAX_PAYLOAD) begin
        start_frame_state(c[3:0]);
        hunt_st = HS_DATA;
      end else begin
        hunt_st = HS_S;
      end
    end else if (hunt_st != HS_DATA) begin
      hunt_st = HS_S;
    end else begin
      if (c == CH_COMMA) begin
        if (field_no < 2'd3) field_no = field_no + 2'd1;
        char_cnt = '0;
      end else if (field_no == 2'd2) begin
        pen = c;
      end else if (field_no < 2'd2 && char_cnt < FIELD_CHARS) begin
        if (field_no == 2'd0) x_parse = parse_char(x_parse, c);
        else y_parse = parse_char(y_parse, c);
        char_cnt = char_cnt + 3'd1;
      end
      if (bytes_left > 0) bytes_left = bytes_left - 4'd1;
      if (bytes_left == 0) begin
        hunt_st = HS_S;
        res = '0;
        if (pen == CH_ONE || pen == CH_THREE) begin
          res.x_pos    = COORD_W'(int'(x_parse.acc) * 1280 / 1024);
          res.y_pos    = COORD_W'(int'(y_parse.acc) * 720 / 600);
          res.pressure = 2'(pen - CH_ZERO);
          res.touching = 1'b1;
        end
        pending_frames.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one byte, possibly after random idle cycles, and returns at the
  // edge where it is accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b);
    sent_bytes++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  task automatic add_header(input int count);
    for (int i = 0; i < count; i++) burst.push_back(sync_char(i));
  endtask

  // One coordinate field: a mix of digits, spaces, signs and junk, or
  // sometimes the largest five-digit value.
  task automatic add_number();
    int n;
    int r;
    n = $urandom_range(0, 7);
    if ($urandom_range(9) == 0) begin
      repeat (5) payload.push_back(CH_NINE);
    end else begin
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 55) payload.push_back(8'(CH_ZERO + $urandom_range(9)));
        else if (r < 70) payload.push_back(CH_SPACE);
        else if (r < 80) payload.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        else payload.push_back(rand_non_comma());
      end
    end
  endtask

  // A well-formed header with a random "x,y,p" body. The length byte
  // mostly matches the body; otherwise it cuts it short or runs past it.
  task automatic add_frame();
    int r;
    int len;
    payload.delete();
    add_number();
    if ($urandom_range(9) != 0) payload.push_back(CH_COMMA);
    add_number();
    if ($urandom_range(9) != 0) payload.push_back(CH_COMMA);
    if ($urandom_range(99) < 85) begin
      r = $urandom_range(99);
      if (r < 35) payload.push_back(CH_ONE);
      else if (r < 65) payload.push_back(CH_THREE);
      else if (r < 80) payload.push_back(CH_ZERO);
      else if (r < 85) payload.push_back(8'h32);
      else payload.push_back(rand_non_comma());
    end
    if ($urandom_range(4) == 0) begin
      payload.push_back(CH_COMMA);
      repeat ($urandom_range(3)) begin
        payload.push_back($urandom_range(3) == 0 ? CH_COMMA : rand_non_comma());
      end
    end
    if ($urandom_range(3) != 0) begin
      len = payload.size();
      if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
      if (len < 1) len = 1;
    end else begin
      len = $urandom_range(1, MAX_PAYLOAD);
    end
    while (payload.size() < len) payload.push_back(rand_non_comma());
    add_header(6);
    burst.push_back(FRAME_ID);
    burst.push_back(8'(len));
    // Bytes past the length fall back into the header hunt.
    foreach (payload[i]) burst.push_back(payload[i]);
  endtask

  // Line noise, frames that break off in the header, ID or length, and a frame behind a doubled 's'.
  task automatic add_broken();
    logic [7:0] b;
    case ($urandom_range(4))
      0: repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(255)));
      1: begin
        add_header($urandom_range(1, 5));
        burst.push_back(8'($urandom_range(255)));
      end
      2: begin
        add_header(6);
        do b = 8'($urandom_range(255)); while (b == FRAME_ID);
        burst.push_back(b);
      end
      3: begin
        add_header(6);
        burst.push_back(FRAME_ID);
        burst.push_back($urandom_range(1) ? 8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end
      default: begin
        // A doubled 's' is dropped and is not retried as a header start.
        burst.push_back(sync_char(0));
        add_frame();
      end
    endcase
  endtask

  task automatic test_directed();
    string body;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // Largest payload: five-digit maxima in both fields, pen code '3' and
    // an extra field after it that must be ignored.
    body = "99999,99999,3,9";
    add_header(6);
    burst.push_back(FRAME_ID);
    burst.push_back(8'(MAX_PAYLOAD));
    for (int i = 0; i < body.len(); i++) burst.push_back(body[i]);
    // A zero length restarts the hunt without a result.
    add_header(6);
    burst.push_back(FRAME_ID);
    burst.push_back(8'd0);
    send_burst();
  endtask

  task automatic test_frames(input int n_bytes, input int idle_pct, input int stall_pct);
    int target;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    target = sent_bytes + n_bytes;
    while (sent_bytes < target) begin
      if ($urandom_range(99) < 75) add_frame();
      else add_broken();
      send_burst();
    end
  endtask

  // Short one-byte frames while the receiver is held off, so that results
  // pile up inside the block until it refuses input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests <= hold_requests + 1;
    repeat (12) begin
      add_header(6);
      burst.push_back(FRAME_ID);
      burst.push_back(8'd1);
      burst.push_back($urandom_range(1) ? CH_NINE : rand_non_comma());
      send_burst();
    end
  endtask

  // Receiver: checks every accepted result and drives tready with random
  // stalls or a requested long hold-off.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      m_tready    <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_frames.size() == 0) begin
          report_mismatch("result with none pending (x_pos)", m_tdata[16:0], 0);
        end else begin
          want = pending_frames.pop_front();
          if (m_tdata[16:0] !== want.x_pos)
            report_mismatch("x_pos", m_tdata[16:0], want.x_pos);
          if (m_tdata[33:17] !== want.y_pos)
            report_mismatch("y_pos", m_tdata[33:17], want.y_pos);
          if (m_tdata[35:34] !== want.pressure)
            report_mismatch("pressure", m_tdata[35:34], want.pressure);
          if (m_tdata[39:36] !== 4'd0)
            report_mismatch("tdata padding", m_tdata[39:36], 0);
          if (m_tuser !== want.touching)
            report_mismatch("touching", m_tuser, want.touching);
        end
      end
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        m_tready    <= 1'b0;
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_CYCLES;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on progress: any accepted item on either side restarts it.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("touch_frame_parser_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = 8'd0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    sent_bytes      = 0;
    mismatches      = 0;
    hold_requests   = 0;
    hunt_st         = HS_S;
    pen             = CH_ZERO;
    start_frame_state(4'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_frames(120, 0, 0);
    test_frames(120, 60, 0);
    test_frames(120, 0, 60);
    test_frames(120, 36, 36);
    test_backpressure();
    test_frames(40, 0, 0);

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("touch_frame_parser_tb: done, clean");
    end else begin
      $display("touch_frame_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tfp_pkg.sv
rtl/core/tfp_digit.sv
rtl/core/touch_frame_parser.sv
rtl/core/tfp_checker.sv
tb/touch_frame_parser_tb.sv
